FILE: hw/rtl/d2b100_pkg.sv
// Shared types and constants of the decimal to base-100 number encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package d2b100_pkg;

   // Format limits
   localparam int MAX_MANTISSA_BYTES     = 19;
   localparam int TERMINATOR_DIGIT_LIMIT = 38;
   localparam int MANT_CNT_W             = $clog2(MAX_MANTISSA_BYTES + 1);

   // Bytes one digit item can produce: length, exponent, mantissa, terminator
   localparam int MAX_GROUP   = 4;
   localparam int SLOT_W      = $clog2(MAX_GROUP);
   localparam int GROUP_CNT_W = $clog2(MAX_GROUP + 1);

   // Group queue; depth must be a power of two (pointers wrap by truncation)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Byte codes
   localparam logic [7:0] ZERO_LENGTH   = 8'd1;
   localparam logic [7:0] ZERO_EXPONENT = 8'h80;
   localparam logic [7:0] EXP_SIGN_BIT  = 8'h80;
   localparam logic [7:0] EXP_MASK      = 8'h7F;
   localparam logic [7:0] EXP_POS_BIAS  = 8'd64;
   localparam logic [7:0] EXP_NEG_BIAS  = 8'd63;
   localparam logic [7:0] NEG_PAIR_BASE = 8'd101;
   localparam logic [7:0] TERMINATOR    = 8'd102;
   localparam logic [5:0] DIGIT_SAT     = 6'd63;

   typedef struct packed {
      logic [3:0]        digit;
      logic              negative;
      logic              is_zero;
      logic signed [7:0] point_position;
      logic [5:0]        digit_count;
      logic              last_digit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // Bytes produced by one digit item, packed from slot 0 upward
   typedef struct packed {
      logic [GROUP_CNT_W-1:0]    count;
      rsp_type [MAX_GROUP-1:0]   slot;
   } group_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      group_type group;
   } head_type;

endpackage

`default_nettype wire

FILE: hw/rtl/decimal_to_base100_number_encoder_unit.sv
// Decimal to base-100 number encoder: one decimal digit per input transfer,
// one record byte per output transfer. A digit's bytes are queued, then loaded
// into the output register that drives rsp. Throughput: one digit per cycle
// unless the queue is full; bytes leave one per cycle unless rsp stalls, and
// the four-group queue absorbs the 2-4 byte bursts of leading digits.
// Reset (synchronous, active high) clears the number state, queue and output.
`default_nettype none

module decimal_to_base100_number_encoder_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   // digit input
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire d2b100_pkg::req_type req_item,
   // record bytes out
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      d2b100_pkg::rsp_type rsp_item
);

   logic                  accept;
   logic                  push;
   logic                  pop;
   logic                  full;
   d2b100_pkg::group_type group;
   d2b100_pkg::head_type  head;

   // Take a digit whenever the queue has room for its byte group
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   // Front: track pairing, pad and cap, and build this digit's bytes
   d2b100_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .accept    (accept),
      .push      (push),
      .group_out (group)
   );

   // Queue: decouple digit intake from byte output
   d2b100_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (group),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   // Back: serialize each group, hold the byte until its transfer
   d2b100_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result byte changed");

   a_zero_group: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.is_zero) |-> push)
      else $error("zero item produced no bytes");

   a_pop_needs_load: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("group retired without a byte on the output");

endmodule

`default_nettype wire

FILE: hw/rtl/d2b100_front.sv
// Front end: holds the per-number state and turns each digit item into a
// group of up to four record bytes. Depends on d2b100_pkg.
`default_nettype none

module d2b100_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire d2b100_pkg::req_type  req_item,
   input  wire logic                 accept,
   output      logic                 push,
   output      d2b100_pkg::group_type group_out
);

   logic [3:0]                        pending_digit_ff, pending_digit_in;
   logic                              pending_valid_ff, pending_valid_in;
   logic [5:0]                        digits_taken_ff, digits_taken_in;
   logic [d2b100_pkg::MANT_CNT_W-1:0] mant_out_ff, mant_out_in;

   logic                first, lead, term, mant_below, lead_use;
   logic                m_emit, m_flag;
   logic [7:0]          m_value, m_code;
   logic [6:0]          pair_sum;
   logic [5:0]          mb_raw, mb;
   logic [7:0]          len_byte, exp_byte;
   logic signed [8:0]   e_adj;
   logic [7:0]          ex;
   logic [d2b100_pkg::GROUP_CNT_W-1:0] k;
   logic [d2b100_pkg::SLOT_W-1:0]      last_idx;

   assign first = (digits_taken_ff == '0);
   assign lead  = req_item.point_position[0];
   assign term  = req_item.negative &&
                  ({1'b0, req_item.digit_count} < 7'(d2b100_pkg::TERMINATOR_DIGIT_LIMIT));

   // Length byte: 1 + capped mantissa bytes + terminator
   assign pair_sum = {1'b0, req_item.digit_count} + {6'd0, lead} + 7'd1;
   assign mb_raw   = pair_sum[6:1];
   assign mb       = (mb_raw > 6'(d2b100_pkg::MAX_MANTISSA_BYTES)) ?
                     6'(d2b100_pkg::MAX_MANTISSA_BYTES) : mb_raw;
   assign len_byte = 8'd1 + {2'd0, mb} + {7'd0, term};

   // Exponent: e + lead is always even, so the halving is exact
   assign e_adj = {req_item.point_position[7], req_item.point_position} + {8'd0, lead};
   assign ex    = 8'(e_adj >>> 1);
   assign exp_byte = req_item.negative ?
                     ((d2b100_pkg::EXP_NEG_BIAS - ex) & d2b100_pkg::EXP_MASK) :
                     (((ex + d2b100_pkg::EXP_POS_BIAS) & d2b100_pkg::EXP_MASK) |
                      d2b100_pkg::EXP_SIGN_BIT);

   // At most one mantissa byte per item: lead digit, completed pair or closing pad
   assign mant_below = (mant_out_ff < d2b100_pkg::MANT_CNT_W'(d2b100_pkg::MAX_MANTISSA_BYTES));
   assign lead_use   = first && lead;
   assign m_emit     = mant_below && (lead_use || pending_valid_ff || req_item.last_digit);

   always_comb begin
      priority if (lead_use) begin
         m_value = {4'd0, req_item.digit};
      end else if (pending_valid_ff) begin
         m_value = ({4'd0, pending_digit_ff} * 8'd10) + {4'd0, req_item.digit};
      end else begin
         m_value = {4'd0, req_item.digit} * 8'd10;
      end
   end

   assign m_code = req_item.negative ? (d2b100_pkg::NEG_PAIR_BASE - m_value) :
                                       (m_value + 8'd1);
   assign m_flag = ((mant_out_ff + 1'b1) ==
                    d2b100_pkg::MANT_CNT_W'(d2b100_pkg::MAX_MANTISSA_BYTES)) && !term;

   // Pack the bytes of this item in record order
   always_comb begin
      group_out = '0;
      k         = '0;
      last_idx  = '0;
      if (req_item.is_zero) begin
         group_out.slot[0] = '{out_byte: d2b100_pkg::ZERO_LENGTH,   last_byte: 1'b0};
         group_out.slot[1] = '{out_byte: d2b100_pkg::ZERO_EXPONENT, last_byte: 1'b1};
         k = d2b100_pkg::GROUP_CNT_W'(2);
      end else begin
         if (first) begin
            group_out.slot[k[d2b100_pkg::SLOT_W-1:0]] = '{out_byte: len_byte, last_byte: 1'b0};
            k = k + 1'b1;
            group_out.slot[k[d2b100_pkg::SLOT_W-1:0]] = '{out_byte: exp_byte, last_byte: 1'b0};
            k = k + 1'b1;
         end
         if (m_emit) begin
            group_out.slot[k[d2b100_pkg::SLOT_W-1:0]] = '{out_byte: m_code, last_byte: m_flag};
            k = k + 1'b1;
         end
         if (req_item.last_digit && term) begin
            group_out.slot[k[d2b100_pkg::SLOT_W-1:0]] =
               '{out_byte: d2b100_pkg::TERMINATOR, last_byte: 1'b0};
            k = k + 1'b1;
         end
         last_idx = k[d2b100_pkg::SLOT_W-1:0] - 1'b1;
         if (req_item.last_digit && (k != '0)) begin
            group_out.slot[last_idx].last_byte = 1'b1;
         end
      end
      group_out.count = k;
   end

   assign push = accept && (group_out.count != '0);

   // Next per-number state
   always_comb begin
      pending_digit_in = pending_digit_ff;
      pending_valid_in = pending_valid_ff;
      digits_taken_in  = digits_taken_ff;
      mant_out_in      = mant_out_ff + {{(d2b100_pkg::MANT_CNT_W-1){1'b0}}, m_emit};
      if (req_item.is_zero || req_item.last_digit) begin
         pending_digit_in = '0;
         pending_valid_in = 1'b0;
         digits_taken_in  = '0;
         mant_out_in      = '0;
      end else begin
         if (!lead_use && mant_below) begin
            if (pending_valid_ff) begin
               pending_digit_in = '0;
               pending_valid_in = 1'b0;
            end else begin
               pending_digit_in = req_item.digit;
               pending_valid_in = 1'b1;
            end
         end
         if (digits_taken_ff != d2b100_pkg::DIGIT_SAT) begin
            digits_taken_in = digits_taken_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_digit_ff <= '0;
         pending_valid_ff <= 1'b0;
         digits_taken_ff  <= '0;
         mant_out_ff      <= '0;
      end else if (accept) begin
         pending_digit_ff <= pending_digit_in;
         pending_valid_ff <= pending_valid_in;
         digits_taken_ff  <= digits_taken_in;
         mant_out_ff      <= mant_out_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/d2b100_queue.sv
// Short queue of byte groups between the front and back ends.
// Depends on d2b100_pkg.
`default_nettype none

module d2b100_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire d2b100_pkg::group_type push_group,
   input  wire logic                  pop,
   output      logic                  full,
   output      d2b100_pkg::head_type  head
);

   d2b100_pkg::group_type             mem_ff [d2b100_pkg::QUEUE_DEPTH];
   logic [d2b100_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [d2b100_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [d2b100_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == d2b100_pkg::QCNT_W'(d2b100_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.group = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + {{(d2b100_pkg::QCNT_W-1){1'b0}}, push}
                               - {{(d2b100_pkg::QCNT_W-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("group pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("group popped from an empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      ((wr_ptr_ff - rd_ptr_ff) == count_ff[d2b100_pkg::QPTR_W-1:0]))
      else $error("queue pointers disagree with occupancy");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |=> head.valid)
      else $error("queue empty right after a push");

endmodule

`default_nettype wire

FILE: hw/rtl/d2b100_back.sv
// Back end: walks the bytes of the head group and drives the registered
// result channel one byte per cycle while not stalled; uses d2b100_pkg.
`default_nettype none

module d2b100_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire d2b100_pkg::head_type head,
   output      logic                 pop,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      d2b100_pkg::rsp_type  rsp_item
);

   logic                          out_valid_ff, out_valid_in;
   d2b100_pkg::rsp_type           out_ff;
   logic [d2b100_pkg::SLOT_W-1:0] cursor_ff, cursor_in;
   logic                          load, at_end;

   assign load   = head.valid && (!out_valid_ff || rsp_ready);
   assign at_end = ({1'b0, cursor_ff} == (head.group.count - 1'b1));
   assign pop    = load && at_end;

   always_comb begin
      cursor_in = cursor_ff;
      if (load) begin
         cursor_in = at_end ? '0 : cursor_ff + 1'b1;
      end
   end

   always_comb begin
      priority if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= head.group.slot[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cursor_ff    <= cursor_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

`default_nettype wire
